@@ sv/etg_pkg.sv @@
package etg_pkg;

  localparam int IN_W   = 24;   // input channel width, UQ8.(IN_W-8)
  localparam int OUT_W  = 16;   // output channel width, UQ0.OUT_W
  localparam int NLANE  = 3;    // red, green, blue
  localparam int CFG_AW = 3;    // two 32-bit registers

  localparam int NSTEP  = 32;   // fraction bits handled by exp2 and log2
  localparam int U_W    = 49;   // exp2 argument, Q32 with integer part
  localparam int Z_W    = 33;   // Q32 value in [0, 1.0]
  localparam int L_W    = 38;   // -log2 result, Q32 up to 32.0

  localparam logic [Z_W-1:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [30:0]    LOG2E_M1 = 31'h7154_7652;   // log2(e) - 1, Q32

  localparam logic [15:0] EXPOSURE_RST  = 16'd256;   // 1.0 in UQ8.8
  localparam logic [15:0] INV_GAMMA_RST = 16'd7447;  // about 1/2.2 in UQ2.14

  // register index codes (paddr bit above the word offset)
  localparam logic REG_EXPOSURE  = 1'b0;
  localparam logic REG_INV_GAMMA = 1'b1;

  typedef struct packed {
    logic             frame_end;
    logic [NLANE-1:0] yzero;     // tone mapped value was exactly zero
  } etg_sb_t;

  typedef logic [31:0] pow_tab_t [NSTEP];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] b;
    n   = n_in;
    res = '0;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // entry k is 2^(-2^-(k+1)) in Q32
  function automatic pow_tab_t pow2_table();
    pow_tab_t    t;
    logic [63:0] r;
    r    = isqrt64(64'h8000_0000_0000_0000);
    t[0] = r[31:0];
    for (int k = 1; k < NSTEP; k++) begin
      r    = isqrt64({t[k-1], 32'h0000_0000});
      t[k] = r[31:0];
    end
    return t;
  endfunction

  localparam pow_tab_t POW2_TAB = pow2_table();

endpackage

@@ sv/etg_front.sv @@
module etg_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  etg_pkg::etg_sb_t            in_sb,
  input  logic [15:0]                 exposure,
  input  logic [etg_pkg::IN_W-1:0]    in_x [etg_pkg::NLANE],
  output logic                        out_valid,
  output etg_pkg::etg_sb_t            out_sb,
  output logic [etg_pkg::U_W-1:0]     out_u [etg_pkg::NLANE]
);
  import etg_pkg::*;

  localparam int P_W = 16 + IN_W;
  localparam int T_W = 48;

  logic            v1_r, v2_r, v3_r;
  etg_sb_t         sb1_r, sb2_r, sb3_r;
  logic [P_W-1:0]  prod_r [NLANE];
  logic [T_W-1:0]  t_sh   [NLANE];
  logic [T_W-1:0]  t_r    [NLANE];
  logic [62:0]     mh_r   [NLANE];
  logic [46:0]     ml_r   [NLANE];
  logic [U_W-1:0]  u_r    [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_r <= in_sb;
      sb2_r <= sb1_r;
      sb3_r <= sb2_r;
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    // t = exposure * x in Q32
    assign t_sh[l] = T_W'(prod_r[l]) << (32 - IN_W);

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[l] <= P_W'(exposure) * P_W'(in_x[l]);
        t_r[l]    <= t_sh[l];
        mh_r[l]   <= 63'(t_sh[l][47:16]) * 63'(LOG2E_M1);
        ml_r[l]   <= 47'(t_sh[l][15:0]) * 47'(LOG2E_M1);
        u_r[l]    <= U_W'(t_r[l]) + U_W'(mh_r[l] >> 16) + U_W'(ml_r[l] >> 32);
      end
    end

    assign out_u[l] = u_r[l];
  end

  assign out_valid = v3_r;
  assign out_sb    = sb3_r;

endmodule

@@ sv/etg_exp2.sv @@
module etg_exp2 (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  etg_pkg::etg_sb_t        in_sb,
  input  logic [etg_pkg::U_W-1:0] in_v [etg_pkg::NLANE],
  output logic                    out_valid,
  output etg_pkg::etg_sb_t        out_sb,
  output logic [etg_pkg::Z_W-1:0] out_z [etg_pkg::NLANE]
);
  import etg_pkg::*;

  localparam int IP_W = U_W - 32;

  logic            vld_r  [NSTEP+1];
  etg_sb_t         sb_r   [NSTEP+1];
  logic [31:0]     frac_r [NSTEP][NLANE];
  logic [31:0]     m_r    [NSTEP][NLANE];
  logic            one_r  [NSTEP][NLANE];   // product still exactly 1.0
  logic            zf_r   [NSTEP][NLANE];   // integer part flushes to zero
  logic [5:0]      sh_r   [NSTEP][NLANE];
  logic [Z_W-1:0]  z_r    [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NSTEP; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j <= NSTEP; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      for (int j = 1; j <= NSTEP; j++) sb_r[j] <= sb_r[j-1];
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    logic [IP_W-1:0] ip;
    logic [Z_W-1:0]  val;

    assign ip = in_v[l][U_W-1:32];

    // first step: product is 1.0, so the table entry is taken directly
    always_ff @(posedge clk) begin
      if (en) begin
        frac_r[0][l] <= in_v[l][31:0];
        one_r[0][l]  <= ~in_v[l][31];
        m_r[0][l]    <= in_v[l][31] ? POW2_TAB[0] : 32'h0;
        zf_r[0][l]   <= (ip > IP_W'(32));
        sh_r[0][l]   <= ip[5:0];
      end
    end

    for (genvar j = 1; j < NSTEP; j++) begin : g_step
      logic [63:0] prod;
      logic        b;

      assign prod = 64'(m_r[j-1][l]) * 64'(POW2_TAB[j]);
      assign b    = frac_r[j-1][l][31-j];

      always_ff @(posedge clk) begin
        if (en) begin
          frac_r[j][l] <= frac_r[j-1][l];
          one_r[j][l]  <= one_r[j-1][l] & ~b;
          zf_r[j][l]   <= zf_r[j-1][l];
          sh_r[j][l]   <= sh_r[j-1][l];
          if (!b) begin
            m_r[j][l] <= m_r[j-1][l];
          end else if (one_r[j-1][l]) begin
            m_r[j][l] <= POW2_TAB[j];
          end else begin
            m_r[j][l] <= prod[63:32];
          end
        end
      end
    end

    assign val = one_r[NSTEP-1][l] ? ONE_Q32 : {1'b0, m_r[NSTEP-1][l]};

    always_ff @(posedge clk) begin
      if (en) begin
        z_r[l] <= zf_r[NSTEP-1][l] ? '0 : (val >> sh_r[NSTEP-1][l]);
      end
    end

    assign out_z[l] = z_r[l];
  end

  assign out_valid = vld_r[NSTEP];
  assign out_sb    = sb_r[NSTEP];

endmodule

@@ sv/etg_log2.sv @@
module etg_log2 (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  etg_pkg::etg_sb_t        in_sb,
  input  logic [etg_pkg::Z_W-1:0] in_y [etg_pkg::NLANE],
  output logic                    out_valid,
  output etg_pkg::etg_sb_t        out_sb,
  output logic [etg_pkg::L_W-1:0] out_l [etg_pkg::NLANE]
);
  import etg_pkg::*;

  // stage 0: top bit, stage 1: normalize, stages 2..33: squarings, 34: result
  localparam int NST = NSTEP + 3;

  logic            vld_r  [NST];
  etg_sb_t         sb_r   [NST];
  logic [Z_W-1:0]  ya_r   [NLANE];
  logic [5:0]      pa_r   [NLANE];
  logic [31:0]     m_r    [NSTEP+1][NLANE];
  logic [31:0]     frac_r [NSTEP+1][NLANE];
  logic [5:0]      pp_r   [NSTEP+1][NLANE];
  logic [L_W-1:0]  l_r    [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NST; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int j = 1; j < NST; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      for (int j = 1; j < NST; j++) sb_r[j] <= sb_r[j-1];
    end
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    logic [5:0]  p_c;
    logic [31:0] mn;

    always_comb begin
      p_c = '0;
      for (int i = 0; i < Z_W; i++) begin
        if (in_y[l][i]) p_c = 6'(i);
      end
    end

    // bring the top bit to bit 31 (Q1.31 mantissa)
    assign mn = (pa_r[l] == 6'd32) ? ya_r[l][32:1]
                                   : (ya_r[l][31:0] << 5'(6'd31 - pa_r[l]));

    always_ff @(posedge clk) begin
      if (en) begin
        ya_r[l]      <= in_y[l];
        pa_r[l]      <= p_c;
        m_r[0][l]    <= mn;
        frac_r[0][l] <= '0;
        pp_r[0][l]   <= pa_r[l];
      end
    end

    for (genvar k = 1; k <= NSTEP; k++) begin : g_sq
      logic [63:0] sq;
      logic [32:0] s;

      assign sq = 64'(m_r[k-1][l]) * 64'(m_r[k-1][l]);
      assign s  = sq[63:31];

      always_ff @(posedge clk) begin
        if (en) begin
          m_r[k][l]    <= s[32] ? s[32:1] : s[31:0];
          frac_r[k][l] <= {frac_r[k-1][l][30:0], s[32]};
          pp_r[k][l]   <= pp_r[k-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        l_r[l] <= (L_W'(6'd32 - pp_r[NSTEP][l]) << 32) - L_W'(frac_r[NSTEP][l]);
      end
    end

    assign out_l[l] = l_r[l];
  end

  assign out_valid = vld_r[NST-1];
  assign out_sb    = sb_r[NST-1];

endmodule

@@ sv/exposure_tonemap_gamma.sv @@
// Exposure tone mapping with gamma, one RGB pixel per request.
// Input channel: in_red/in_green/in_blue are linear UQ8.16 radiance, in_frame_end
// marks the last pixel of a frame; a request is taken when in_valid is high
// and in_stall is low. Output channel: out_red/out_green/out_blue are UQ0.16
// values of (1 - exp(-exposure * x)) ^ inv_gamma, with exact 1.0 saturated to
// all ones; out_frame_end is the input marker, unchanged.
// Configuration: APB-style port, exposure (UQ8.8) at 0x0 and inv_gamma
// (UQ2.14) at 0x4; write them only while no pixel is in flight.
// Throughput: one pixel per clock while in_stall is low, no dependence between pixels.
// Depth: set by the two 32-step exp2 multiplier chains and the 32-step log2
// squaring chain, one multiply per register stage.
// Reset: clears all valid bits and the skid buffer, loads exposure = 1.0 and
// inv_gamma = 7447 (about 1/2.2). No memory, so no clearing pass.
// Back-pressure: an output register plus a one-entry skid buffer. A stalled
// output keeps the pipeline running until the skid fills; then in_stall rises
// (registered) and every stage holds until the receiver takes a result.
module exposure_tonemap_gamma (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [etg_pkg::IN_W-1:0]     in_red,
  input  logic [etg_pkg::IN_W-1:0]     in_green,
  input  logic [etg_pkg::IN_W-1:0]     in_blue,
  input  logic                         in_frame_end,
  // pixel output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [etg_pkg::OUT_W-1:0]    out_red,
  output logic [etg_pkg::OUT_W-1:0]    out_green,
  output logic [etg_pkg::OUT_W-1:0]    out_blue,
  output logic                         out_frame_end,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [etg_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import etg_pkg::*;

  typedef struct packed {
    logic                        frame_end;
    logic [NLANE-1:0][OUT_W-1:0] ch;
  } pix_t;

  localparam logic [33:0]      RND_BIAS = 34'(1) << (31 - OUT_W);

  // ---------------------------------------------------------------- config
  logic [15:0] exposure_r;
  logic [15:0] inv_gamma_r;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exposure_r  <= EXPOSURE_RST;
      inv_gamma_r <= INV_GAMMA_RST;
    end else if (cfg_wr) begin
      case (paddr[CFG_AW-1])
        REG_EXPOSURE:  exposure_r  <= pwdata[15:0];
        REG_INV_GAMMA: inv_gamma_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1])
      REG_EXPOSURE:  prdata = {16'h0000, exposure_r};
      REG_INV_GAMMA: prdata = {16'h0000, inv_gamma_r};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- control
  // Whole pipeline advances together; it freezes only when the skid is full.
  logic en;
  logic skid_full_r;
  logic out_valid_r;
  logic out_take;

  assign en       = ~skid_full_r;
  assign in_stall = skid_full_r;
  assign out_take = out_valid_r & ~out_stall;

  // ---------------------------------------------------------------- front end
  logic [IN_W-1:0] pix_in [NLANE];
  etg_sb_t         front_sb;
  logic            fr_valid;
  etg_sb_t         fr_sb;
  logic [U_W-1:0]  fr_u [NLANE];

  assign pix_in[0] = in_red;
  assign pix_in[1] = in_green;
  assign pix_in[2] = in_blue;
  assign front_sb  = '{frame_end: in_frame_end, yzero: '0};

  // exposure multiply and conversion to base 2
  etg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_sb     (front_sb),
    .exposure  (exposure_r),
    .in_x      (pix_in),
    .out_valid (fr_valid),
    .out_sb    (fr_sb),
    .out_u     (fr_u)
  );

  // exp(-exposure * x)
  logic           ea_valid;
  etg_sb_t        ea_sb;
  logic [Z_W-1:0] ea_z [NLANE];

  etg_exp2 u_exp_tone (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_sb     (fr_sb),
    .in_v      (fr_u),
    .out_valid (ea_valid),
    .out_sb    (ea_sb),
    .out_z     (ea_z)
  );

  // ---------------------------------------------------------------- y = 1 - e
  // Flag an exact zero here; log2 is undefined there and the gamma result
  // is patched at the rounding stage.
  logic           y_vld_r;
  etg_sb_t        y_sb_r;
  logic [Z_W-1:0] y_r [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r <= 1'b0;
    end else if (en) begin
      y_vld_r <= ea_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_sb_r.frame_end <= ea_sb.frame_end;
      for (int l = 0; l < NLANE; l++) begin
        y_r[l]          <= ONE_Q32 - ea_z[l];
        y_sb_r.yzero[l] <= (ea_z[l] == ONE_Q32);
      end
    end
  end

  // ---------------------------------------------------------------- -log2(y)
  logic           lg_valid;
  etg_sb_t        lg_sb;
  logic [L_W-1:0] lg_l [NLANE];

  etg_log2 u_log2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (y_vld_r),
    .in_sb     (y_sb_r),
    .in_y      (y_r),
    .out_valid (lg_valid),
    .out_sb    (lg_sb),
    .out_l     (lg_l)
  );

  // ---------------------------------------------------------------- gamma
  // inv_gamma * L split into two partial products, summed in the next stage.
  logic           g1_vld_r, g2_vld_r;
  etg_sb_t        g1_sb_r,  g2_sb_r;
  logic [21:0]    ph_r [NLANE];
  logic [47:0]    pl_r [NLANE];
  logic [U_W-1:0] gv_r [NLANE];
  logic [53:0]    gsum [NLANE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
    end else if (en) begin
      g1_vld_r <= lg_valid;
      g2_vld_r <= g1_vld_r;
    end
  end

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      gsum[l] = (54'(ph_r[l]) << 32) + 54'(pl_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1_sb_r <= lg_sb;
      g2_sb_r <= g1_sb_r;
      for (int l = 0; l < NLANE; l++) begin
        ph_r[l] <= 22'(inv_gamma_r) * 22'(lg_l[l][L_W-1:32]);
        pl_r[l] <= 48'(inv_gamma_r) * 48'(lg_l[l][31:0]);
        gv_r[l] <= U_W'(gsum[l] >> 14);
      end
    end
  end

  // y ^ inv_gamma = 2^-(inv_gamma * L)
  logic           eb_valid;
  etg_sb_t        eb_sb;
  logic [Z_W-1:0] eb_z [NLANE];

  etg_exp2 u_exp_gamma (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g2_vld_r),
    .in_sb     (g2_sb_r),
    .in_v      (gv_r),
    .out_valid (eb_valid),
    .out_sb    (eb_sb),
    .out_z     (eb_z)
  );

  // ---------------------------------------------------------------- round
  logic            rnd_valid_r;
  pix_t            rnd_r;
  pix_t            rnd_nxt;
  logic [Z_W-1:0]  zsel [NLANE];
  logic [33:0]     rsum [NLANE];
  logic [OUT_W+1:0] rq  [NLANE];

  always_comb begin
    rnd_nxt.frame_end = eb_sb.frame_end;
    for (int l = 0; l < NLANE; l++) begin
      // zero input: 0^inv_gamma is 0, but 0^0 is 1
      if (eb_sb.yzero[l]) begin
        zsel[l] = (inv_gamma_r == 16'h0000) ? ONE_Q32 : '0;
      end else begin
        zsel[l] = eb_z[l];
      end
      rsum[l] = 34'(zsel[l]) + RND_BIAS;
      rq[l]   = rsum[l][33:32-OUT_W];
      // saturate an exact 1.0 to all ones
      rnd_nxt.ch[l] = (|rq[l][OUT_W+1:OUT_W]) ? '1 : rq[l][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_valid_r <= 1'b0;
    end else if (en) begin
      rnd_valid_r <= eb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r <= rnd_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  // Output register plus skid: the request leaving the round stage goes to
  // the output register when it is free or being taken, else into the skid.
  pix_t out_r;
  pix_t skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      // drain the skid once the held request is taken
      if (out_take) begin
        skid_full_r <= 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_r <= rnd_valid_r;
    end else if (rnd_valid_r) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (!out_valid_r || out_take) begin
      out_r <= rnd_r;
    end else begin
      skid_r <= rnd_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_r.ch[0];
  assign out_green     = out_r.ch[1];
  assign out_blue      = out_r.ch[2];
  assign out_frame_end = out_r.frame_end;

  // ---------------------------------------------------------------- checks
  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds a request while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && out_stall && rnd_valid_r))
    else $error("skid filled without a blocked output and a pending request");

  a_freeze_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(rnd_valid_r) && $stable(rnd_r)))
    else $error("last pipeline stage moved while the pipeline was frozen");

endmodule

@@ sim/exposure_tonemap_gamma_test.sv @@
module exposure_tonemap_gamma_test;

  localparam int IN_W  = etg_pkg::IN_W;
  localparam int OUT_W = etg_pkg::OUT_W;

  // Timing budget: the pipeline is 109 deep, so the DRAIN_CYCLES quiet stretch
  // at the end is ample; the watchdog tolerates the long receiver hold-off.
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int PHASE_ITEMS  = 210;

  typedef struct packed {
    logic [IN_W-1:0] red;
    logic [IN_W-1:0] green;
    logic [IN_W-1:0] blue;
    logic            frame_end;
  } radiance_px_t;

  typedef struct packed {
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
    logic             frame_end;
  } display_px_t;

  // Scoreboard: predicts each accepted request with its own copy of the
  // exposure and inverse gamma registers and checks results in order.
  class tonemap_scoreboard;
    localparam logic [63:0] LOG2E_FRAC = 64'h7154_7652;  // log2(e) - 1, Q32
    localparam logic [63:0] UNITY_Q32  = 64'h1_0000_0000;

    logic [15:0] exposure_q88;
    logic [15:0] inv_gamma_q214;
    logic [63:0] root2_q32 [32];   // 2^(-2^-(k+1)) in Q32
    display_px_t expected_pixels [$];
    int          fail_count;
    int          checked;
    int          saturated;
    int          zeros;
    int          frame_ends;

    function new();
      exposure_q88   = 16'd256;
      inv_gamma_q214 = 16'd7447;
      root2_q32[0]   = int_sqrt(64'h8000_0000_0000_0000);
      for (int k = 1; k < 32; k++) root2_q32[k] = int_sqrt(root2_q32[k-1] << 32);
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] b;
      rem  = n;
      root = '0;
      b    = 64'h4000_0000_0000_0000;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
        if (rem >= root + b) begin
          rem  = rem - (root + b);
          root = (root >> 1) + b;
        end else begin
          root = root >> 1;
        end
        b = b >> 2;
      end
      return root;
    endfunction

    // 2^-v, v in Q32 with integer part; result in Q32
    function logic [63:0] pow2_neg(logic [63:0] v);
      logic [63:0] whole;
      logic [63:0] m;
      whole = v >> 32;
      m     = UNITY_Q32;
      if (whole >= 64) return '0;
      for (int k = 0; k < 32; k++) begin
        if (v[31-k]) m = (m * root2_q32[k]) >> 32;
      end
      return m >> whole;
    endfunction

    // -log2(y) for y in (0, 1.0], Q32 in and out
    function logic [63:0] neg_log2(logic [63:0] y);
      int          p;
      logic [63:0] m;
      logic [63:0] frac;
      p    = 32;
      frac = '0;
      while (p > 0 && !y[p]) p--;
      m = (p > 31) ? (y >> (p - 31)) : (y << (31 - p));
      for (int k = 0; k < 32; k++) begin
        m    = (m * m) >> 31;
        frac = frac << 1;
        if (m >= UNITY_Q32) begin
          frac[0] = 1'b1;
          m       = m >> 1;
        end
      end
      return (64'(32 - p) << 32) - frac;
    endfunction

    function logic [OUT_W-1:0] tone_map_channel(logic [IN_W-1:0] x);
      logic [63:0] t;
      logic [63:0] u;
      logic [63:0] y;
      logic [63:0] z;
      logic [63:0] o;
      t = (64'(exposure_q88) * 64'(x)) << (32 - IN_W);
      u = t + (((t >> 16) * LOG2E_FRAC) >> 16) + (((t & 64'hFFFF) * LOG2E_FRAC) >> 32);
      y = UNITY_Q32 - pow2_neg(u);
      if (y == 0) z = (inv_gamma_q214 == 0) ? UNITY_Q32 : 64'd0;
      else        z = pow2_neg((64'(inv_gamma_q214) * neg_log2(y)) >> 14);
      o = (z + (64'd1 << (31 - OUT_W))) >> (32 - OUT_W);
      if (o > {OUT_W{1'b1}}) o = {OUT_W{1'b1}};
      return o[OUT_W-1:0];
    endfunction

    function void set_register(logic idx, logic [15:0] value);
      if (idx == etg_pkg::REG_EXPOSURE) exposure_q88 = value;
      else                              inv_gamma_q214 = value;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note_request(radiance_px_t px);
      display_px_t want;
      want.red       = tone_map_channel(px.red);
      want.green     = tone_map_channel(px.green);
      want.blue      = tone_map_channel(px.blue);
      want.frame_end = px.frame_end;
      expected_pixels.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(display_px_t got);
      display_px_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("frame_end", want.frame_end, got.frame_end);
      checked++;
      frame_ends += want.frame_end;
      saturated += (want.red == '1) + (want.green == '1) + (want.blue == '1);
      zeros     += (want.red == '0) + (want.green == '0) + (want.blue == '0);
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [IN_W-1:0]           in_red;
  logic [IN_W-1:0]           in_green;
  logic [IN_W-1:0]           in_blue;
  logic                      in_frame_end;
  logic                      out_valid;
  logic                      out_stall;
  logic [OUT_W-1:0]          out_red;
  logic [OUT_W-1:0]          out_green;
  logic [OUT_W-1:0]          out_blue;
  logic                      out_frame_end;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [etg_pkg::CFG_AW-1:0] paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  tonemap_scoreboard sb;
  bit                hold_off_req;   // main asks the receiver for one long hold-off
  int                settings_used;
  int                idle_cycles;

  exposure_tonemap_gamma uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Sample both channels at the rising edge; inputs only move on the falling
  // edge, so the handshake seen here is the one the block sees.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_request('{red: in_red, green: in_green, blue: in_blue,
                        frame_end: in_frame_end});
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{red: out_red, green: out_green, blue: out_blue,
                        frame_end: out_frame_end});
  end

  // Watchdog: count cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles at %0t", idle_cycles, $time);
      $display("exposure_tonemap_gamma_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall on its own pattern of segments, each with its own stall
  // density (zero density gives stretches of full throughput). On request,
  // hold off for a long stretch so the pipeline and skid fill and the input
  // stalls while the sender keeps offering.
  initial begin
    int seg_left;
    int stall_pct;
    bit held;
    seg_left  = 0;
    stall_pct = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        held      = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 200);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Offer one request and hold it until accepted; return on a falling edge.
  task automatic push_pixel(radiance_px_t px);
    in_valid     = 1'b1;
    in_red       = px.red;
    in_green     = px.green;
    in_blue      = px.blue;
    in_frame_end = px.frame_end;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic push_rgb(logic [IN_W-1:0] r, logic [IN_W-1:0] g, logic [IN_W-1:0] b,
                          logic fe);
    push_pixel('{red: r, green: g, blue: b, frame_end: fe});
  endtask

  // Drop valid and wait until every predicted result is back.
  task automatic drain();
    in_valid = 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Write one register with junk in the unused upper bits, then read it back.
  task automatic cfg_write(logic idx, logic [15:0] value);
    logic [31:0] noise;
    logic [31:0] readback;
    noise   = $urandom();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {noise[31:16], value};
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    if (readback != {16'h0000, value}) begin
      $display("%0t: register %0d readback mismatch, expected %h, actual %h",
               $time, idx, {16'h0000, value}, readback);
      sb.fail_count++;
    end
  endtask

  task automatic set_tonemap(logic [15:0] exposure, logic [15:0] inv_gamma);
    cfg_write(etg_pkg::REG_EXPOSURE, exposure);
    cfg_write(etg_pkg::REG_INV_GAMMA, inv_gamma);
    settings_used++;
  endtask

  // Mix full-range radiance with values around 1.0 and below, so both the
  // saturated and the well-graded parts of the curve get exercised.
  function automatic logic [IN_W-1:0] random_channel();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 6))
      0, 1:    return r[IN_W-1:0];
      2:       return IN_W'($urandom_range(0, 65535));
      3:       return IN_W'($urandom_range(0, 255));
      4:       return IN_W'($urandom_range(0, 1 << 20));
      5:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic radiance_px_t random_pixel();
    radiance_px_t px;
    px.red       = random_channel();
    px.green     = random_channel();
    px.blue      = random_channel();
    px.frame_end = ($urandom_range(0, 15) == 0);
    return px;
  endfunction

  function automatic logic [15:0] pick_exposure();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(64, 1024));
      2:       return 16'($urandom_range(1, 32));
      default: return 16'($urandom_range(1024, 8192));
    endcase
  endfunction

  function automatic logic [15:0] pick_inv_gamma();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(4096, 16384));
      2:       return 16'd16384;
      default: return 16'($urandom_range(6000, 9000));
    endcase
  endfunction

  // A few fixed corners run under every special register setting.
  task automatic push_corners();
    push_rgb('0, '1, 24'h01_0000, 1'b0);
    push_rgb('1, 24'h00_0001, 24'h80_0000, 1'b1);
    push_rgb(24'h00_00FF, 24'hFF_0000, 24'h00_FFFF, 1'b0);
    push_pixel(random_pixel());
    drain();
  endtask

  // Random traffic in bursts of random length with random gaps. Optionally
  // start with the receiver holding off while one long burst keeps pushing,
  // and optionally pause halfway until every result is back.
  task automatic stream_random(int n, bit with_hold, bit with_pause);
    int left;
    int burst;
    int gap;
    bit paused;
    left   = n;
    paused = 1'b0;
    if (with_hold) hold_off_req = 1'b1;
    while (left > 0) begin
      burst = (with_hold && left == n) ? 260 : $urandom_range(1, 48);
      if (burst > left) burst = left;
      repeat (burst) push_pixel(random_pixel());
      left -= burst;
      if (with_pause && !paused && left < n / 2) begin
        paused = 1'b1;
        drain();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        if (gap > 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    drain();
  endtask

  initial begin
    sb            = new();
    hold_off_req  = 1'b0;
    settings_used = 1;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_red        = '0;
    in_green      = '0;
    in_blue       = '0;
    in_frame_end  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset registers: exposure 1.0, gamma 2.2. Cover field extremes, the
    // zero channel, exactly 1.0, single bits and alternating patterns.
    push_rgb('0, '0, '0, 1'b0);
    push_rgb('1, '1, '1, 1'b1);
    push_rgb(24'h00_0001, 24'h00_0002, 24'h00_0004, 1'b0);
    push_rgb(24'h01_0000, 24'h00_8000, 24'h00_0100, 1'b0);
    push_rgb(24'hAA_AAAA, 24'h55_5555, 24'h80_0000, 1'b1);
    push_rgb(24'h00_4000, 24'h02_0000, 24'h00_1000, 1'b0);
    push_rgb(24'h00_0010, 24'h7F_FFFF, '0, 1'b0);
    drain();

    // Zero exposure maps everything to black; zero inverse gamma saturates
    // everything, including the zero to the power zero case; full exposure
    // underflows the exponential and saturates; tiny registers stress rounding.
    set_tonemap(16'd0, 16'd7447);
    push_corners();
    set_tonemap(16'hFFFF, 16'd0);
    push_corners();
    set_tonemap(16'd0, 16'd0);
    push_corners();
    set_tonemap(16'hFFFF, 16'hFFFF);
    push_corners();
    set_tonemap(16'd1, 16'd1);
    push_corners();

    // Random phases; the first returns to the reset setting and carries the
    // long receiver hold-off, a later one pauses the sender until drained.
    for (int p = 0; p < 8; p++) begin
      if (p == 0) set_tonemap(16'd256, 16'd7447);
      else        set_tonemap(pick_exposure(), pick_inv_gamma());
      stream_random(PHASE_ITEMS, p == 0, p == 3);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d pixels (%0d frame ends) under %0d register settings",
             sb.checked, sb.frame_ends, settings_used);
    $display("zero and full-scale exposure and inverse gamma; %0d channels saturated, %0d black",
             sb.saturated, sb.zeros);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("exposure_tonemap_gamma_test: clean");
    end else begin
      $display("exposure_tonemap_gamma_test: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/etg_pkg.sv
sv/etg_front.sv
sv/etg_exp2.sv
sv/etg_log2.sv
sv/exposure_tonemap_gamma.sv
sim/exposure_tonemap_gamma_test.sv
